FILE: hw/rtl/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg: shared types and constants of the system control coprocessor
// Request and result layouts, sub-opcode and status codes, register numbers,
// exception vectors, and the command group from controller to datapath.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int unsigned RegCount    = 32;
    localparam int unsigned RegIdxWidth = 5;
    localparam int unsigned DataWidth   = 32;

    // Coprocessor sub-opcodes
    localparam logic [4:0] COP_MFC = 5'd0;
    localparam logic [4:0] COP_CFC = 5'd2;
    localparam logic [4:0] COP_MTC = 5'd4;
    localparam logic [4:0] COP_CTC = 5'd6;
    localparam logic [4:0] COP_RFE = 5'd16;

    // Request kinds
    localparam logic OP_COP = 1'b0;
    localparam logic OP_EXC = 1'b1;

    // Result status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_RANGE     = 2'd1;
    localparam logic [1:0] STS_UNHANDLED = 2'd2;

    // Register numbers
    localparam logic [4:0] REG_BADVADDR = 5'd8;
    localparam logic [4:0] REG_SR       = 5'd12;
    localparam logic [4:0] REG_CAUSE    = 5'd13;
    localparam logic [4:0] REG_EPC      = 5'd14;

    localparam logic [4:0] EXC_BREAKPOINT = 5'd9;

    // Status register fields
    localparam int unsigned SR_BEV_BIT = 22;

    // Cause register fields
    localparam int unsigned CAUSE_BD_BIT = 31;
    localparam logic [31:0] CAUSE_SW_MASK = 32'h0000_0300;

    // Exception vectors
    localparam logic [31:0] VEC_BOOT_BREAK = 32'hBFC0_0140;
    localparam logic [31:0] VEC_BOOT_GEN   = 32'hBFC0_0180;
    localparam logic [31:0] VEC_RAM_BREAK  = 32'h8000_0040;
    localparam logic [31:0] VEC_RAM_GEN    = 32'h8000_0080;

    localparam logic [31:0] EPC_STEP      = 32'd4;
    localparam logic [31:0] EPC_STEP_SLOT = 32'd8;

    typedef struct packed {
        logic        op;
        logic [4:0]  cop_code;
        logic [4:0]  reg_index;
        logic [31:0] write_data;
        logic [4:0]  exc_code;
        logic [31:0] pc;
        logic        in_delay_slot;
        logic        has_bad_address;
        logic [31:0] bad_address;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        read_valid;
        logic [31:0] new_pc;
        logic        pc_valid;
        logic [1:0]  status;
    } result_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } scc_cmd_t;

endpackage

FILE: hw/rtl/scc_ctrl.sv
// ----------------------------------------------------------------------------
// scc_ctrl: request sequencer of the system control coprocessor
// Takes one request at a time, starts its execution once the output
// register is free, and tracks the result valid flag.
// ----------------------------------------------------------------------------
module scc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              res_valid,
    input  logic              res_stall,
    output scc_pkg::scc_cmd_t cmd
);
    import scc_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;

    assign out_free = !out_valid_reg || !res_stall;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    cmd.execute = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drop the flag once taken, set it when a new result lands
    always_comb
    begin
        out_valid_next = out_valid_reg && res_stall;
        if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign res_valid = out_valid_reg;

endmodule

FILE: hw/rtl/scc_datapath.sv
// ----------------------------------------------------------------------------
// scc_datapath: register file and execution logic
// Holds the captured request, the 32-entry control register file and the
// result register; updates the file and loads the result on execute.
// ----------------------------------------------------------------------------
module scc_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  scc_pkg::scc_cmd_t cmd,
    input  scc_pkg::req_t     req_data,
    output scc_pkg::result_t  res_data
);
    import scc_pkg::*;

    req_t        req_reg;
    result_t     res_reg;
    result_t     res_next;
    logic [31:0] regs_reg  [RegCount];
    logic [31:0] regs_next [RegCount];
    logic [31:0] sr_val;
    logic [31:0] cause_val;
    logic [31:0] cause_new;
    logic        bev;

    assign sr_val    = regs_reg[REG_SR];
    assign cause_val = regs_reg[REG_CAUSE];
    assign bev       = sr_val[SR_BEV_BIT];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req_data;
        end
    end

    always_comb
    begin
        regs_next = regs_reg;
        res_next  = '0;
        cause_new = cause_val;
        if (req_reg.op == OP_COP)
        begin
            case (req_reg.cop_code)
                COP_MFC:
                begin
                    res_next.read_data  = regs_reg[req_reg.reg_index];
                    res_next.read_valid = 1'b1;
                end
                COP_CFC, COP_CTC:
                begin
                    res_next.status = STS_RANGE;
                end
                COP_MTC:
                begin
                    if (req_reg.reg_index == REG_CAUSE)
                    begin
                        regs_next[REG_CAUSE] = (cause_val & ~CAUSE_SW_MASK)
                                             | (req_reg.write_data & CAUSE_SW_MASK);
                    end
                    else
                    begin
                        regs_next[req_reg.reg_index] = req_reg.write_data;
                    end
                end
                COP_RFE:
                begin
                    // Pop the mode/interrupt stack, keep the oldest pair
                    regs_next[REG_SR] = {sr_val[31:4], sr_val[5:4], sr_val[3:2]};
                end
                default:
                begin
                    res_next.status = STS_UNHANDLED;
                end
            endcase
        end
        else
        begin
            if (req_reg.has_bad_address)
            begin
                regs_next[REG_BADVADDR] = req_reg.bad_address;
            end
            cause_new[6:2] = req_reg.exc_code;
            if (req_reg.in_delay_slot)
            begin
                regs_next[REG_EPC]      = req_reg.pc - EPC_STEP_SLOT;
                cause_new[CAUSE_BD_BIT] = 1'b1;
            end
            else
            begin
                regs_next[REG_EPC] = req_reg.pc - EPC_STEP;
            end
            regs_next[REG_CAUSE] = cause_new;
            if (req_reg.exc_code == EXC_BREAKPOINT)
            begin
                res_next.new_pc = bev ? VEC_BOOT_BREAK : VEC_RAM_BREAK;
            end
            else
            begin
                res_next.new_pc = bev ? VEC_BOOT_GEN : VEC_RAM_GEN;
            end
            res_next.pc_valid = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RegCount; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else if (cmd.execute)
        begin
            regs_reg <= regs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            res_reg <= res_next;
        end
    end

    assign res_data = res_reg;

endmodule

FILE: hw/rtl/system_control_coprocessor.sv
// ----------------------------------------------------------------------------
// system_control_coprocessor: system control register file and exception unit
// Executes coprocessor move/return requests and exception entries against
// 32 system control registers and returns one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: req_valid/req_stall/req_data. A request is taken at a
//   clock edge with req_valid high and req_stall low. It is either a
//   coprocessor instruction (mfc, mtc, rfe, cfc/ctc) or an exception entry.
//   Result channel: res_valid/res_stall/res_data, exactly one result per
//   request, in request order.
//   The request is captured at the accepting edge and executed into the
//   result register once the output register is free.
//   A new request is taken only after the previous one has executed, set
//   by the capture/execute sequence of the controller around the register
//   file update.
//   A finished result waits in the output register; the next request is
//   taken meanwhile, and its execution waits until the result is taken.
//   While res_stall is high the result holds and req_stall rises after the
//   next request is captured.
//   Reset clears all 32 control registers to zero and empties the block.
// ----------------------------------------------------------------------------
module system_control_coprocessor (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  scc_pkg::req_t    req_data,
    output logic             res_valid,
    input  logic             res_stall,
    output scc_pkg::result_t res_data
);
    import scc_pkg::*;

    // Controller to datapath commands
    scc_cmd_t cmd;

    // Sequence capture and execute, own the result valid flag
    scc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .cmd       (cmd)
    );

    // Register file, request/result registers and execution logic
    scc_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req_data (req_data),
        .res_data (res_data)
    );

endmodule
